FILE: rtl/clb_pkg.sv
`default_nettype none
package clb_pkg;
    localparam int MAX_PARTICLES_DEF = 4096;
    localparam int MAX_CELLS_DEF     = 4096;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int CFG_W             = 5;
    localparam int CFG_IDX_W         = 2;
    localparam int COORD_W           = 17;

    localparam logic [2:0] FUNC_CLEAR  = 3'd0;
    localparam logic [2:0] FUNC_INSERT = 3'd1;
    localparam logic [2:0] FUNC_MOVE   = 3'd2;
    localparam logic [2:0] FUNC_HEAD   = 3'd3;
    localparam logic [2:0] FUNC_NEXT   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic [11:0]        particle;
        logic [COORD_W-1:0] old_x;
        logic [COORD_W-1:0] old_y;
        logic [COORD_W-1:0] old_z;
        logic [COORD_W-1:0] new_x;
        logic [COORD_W-1:0] new_y;
        logic [COORD_W-1:0] new_z;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] cell_id;
        logic [11:0] entry_particle;
        logic        entry_valid;
    } t_out_word;

    // saturated cell count, 3..16
    function automatic logic [4:0] sat_cells(input logic [4:0] r);
        if (r < 5'd3) return 5'd3;
        if (r > 5'd16) return 5'd16;
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/clb_binner.sv
`default_nettype none
// Pipelined binning: multiply per axis into a register, then row-major combine into the output register.
module clb_binner #(
    parameter int FRAC_BITS = clb_pkg::FRAC_BITS_DEF,
    parameter int MAX_CELLS = clb_pkg::MAX_CELLS_DEF,
    parameter int CW        = $clog2(MAX_CELLS)
) (
    input  wire logic                        i_clk,
    input  wire logic [4:0]                  i_cx,
    input  wire logic [4:0]                  i_cy,
    input  wire logic [4:0]                  i_cz,
    input  wire logic [clb_pkg::COORD_W-1:0] i_x,
    input  wire logic [clb_pkg::COORD_W-1:0] i_y,
    input  wire logic [clb_pkg::COORD_W-1:0] i_z,
    output      logic [CW-1:0]               o_cell,
    output      logic                        o_ok
);
    localparam int PW = clb_pkg::COORD_W + 5;
    logic [PW-1:0] px, py, pz;
    logic [PW-1:0] bx, by, bz;
    logic [PW-1:0] r_bx, r_by, r_bz;
    logic          r_axok;
    logic [4:0]    r_cx, r_cy;
    logic [20:0]   sum;

    assign px = PW'(i_x) * PW'(i_cx);
    assign py = PW'(i_y) * PW'(i_cy);
    assign pz = PW'(i_z) * PW'(i_cz);
    assign bx = px >> FRAC_BITS;
    assign by = py >> FRAC_BITS;
    assign bz = pz >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        r_bx   <= bx;
        r_by   <= by;
        r_bz   <= bz;
        r_cx   <= i_cx;
        r_cy   <= i_cy;
        r_axok <= (bx < PW'(i_cx)) && (by < PW'(i_cy)) && (bz < PW'(i_cz));
    end

    assign sum = 21'(r_cx) * 21'(r_cy) * 21'(r_bz[4:0]) + 21'(r_cx) * 21'(r_by[4:0])
               + 21'(r_bx[4:0]);

    always_ff @(posedge i_clk) begin
        o_ok   <= r_axok && (sum < 21'(MAX_CELLS));
        o_cell <= CW'(sum);
    end
endmodule
`default_nettype wire

FILE: rtl/clb_ctrl.sv
`default_nettype none
// Sequencer over the head and successor memories.
module clb_ctrl #(
    parameter int MAX_PARTICLES = clb_pkg::MAX_PARTICLES_DEF,
    parameter int MAX_CELLS     = clb_pkg::MAX_CELLS_DEF,
    parameter int FRAC_BITS     = clb_pkg::FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [4:0]        i_cx,
    input  wire logic [4:0]        i_cy,
    input  wire logic [4:0]        i_cz,
    input  wire logic              i_valid,
    output      logic              o_stall,
    input  wire clb_pkg::t_in_word i_data,
    output      logic              o_valid,
    input  wire logic              i_stall,
    output      clb_pkg::t_out_word o_data,
    output      logic              o_busy
);
    localparam int CW = $clog2(MAX_CELLS);
    localparam int PW = $clog2(MAX_PARTICLES);
    localparam int SW = PW + 1;
    localparam int EW = PW + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BIN1  = 4'd1;
    localparam logic [3:0] S_BIN2  = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_RDH   = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_WALK  = 4'd6;
    localparam logic [3:0] S_UNL   = 4'd7;
    localparam logic [3:0] S_PUSHR = 4'd8;
    localparam logic [3:0] S_PUSHW = 4'd9;
    localparam logic [3:0] S_RDQ   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_CLR   = 4'd12;
    localparam logic [3:0] S_RDN   = 4'd13;
    localparam logic [3:0] S_NQ    = 4'd14;

    // head memory: epoch tag clears in one step; the tag wraps with a sweep
    localparam int TW = 4;
    logic [TW+EW-1:0] m_head [MAX_CELLS];
    logic [EW-1:0]    m_next [MAX_PARTICLES];
    logic [TW+EW-1:0] r_hq;
    logic [EW-1:0]    r_nq;
    logic [TW-1:0]    r_epoch;

    logic [3:0]   r_st;
    clb_pkg::t_in_word r_in;
    logic [1:0]   r_status;
    logic [CW-1:0] r_oc, r_nc, r_oidx;
    logic [EW-1:0] r_cur;
    logic [PW-1:0] r_prev;
    logic         r_hprev;
    logic [SW-1:0] r_steps;
    logic [EW-1:0] r_ep;
    logic [CW-1:0] r_clr;
    logic         r_clr_run;

    logic [CW-1:0] b_cell_o, b_cell_n;
    logic          b_ok_o, b_ok_n;
    logic          p_ok;
    logic [EW-1:0] hd;

    clb_binner #(.FRAC_BITS(FRAC_BITS), .MAX_CELLS(MAX_CELLS), .CW(CW)) u_bo (
        .i_clk, .i_cx, .i_cy, .i_cz,
        .i_x(r_in.old_x), .i_y(r_in.old_y), .i_z(r_in.old_z),
        .o_cell(b_cell_o), .o_ok(b_ok_o));
    clb_binner #(.FRAC_BITS(FRAC_BITS), .MAX_CELLS(MAX_CELLS), .CW(CW)) u_bn (
        .i_clk, .i_cx, .i_cy, .i_cz,
        .i_x(r_in.new_x), .i_y(r_in.new_y), .i_z(r_in.new_z),
        .o_cell(b_cell_n), .o_ok(b_ok_n));

    assign p_ok  = 32'(r_in.particle) < 32'(MAX_PARTICLES);
    // head entry reads empty unless its tag matches the current epoch
    assign hd    = (r_hq[TW+EW-1 -: TW] == r_epoch) ? r_hq[EW-1:0] : '0;
    assign o_stall = (r_st != S_IDLE) || r_clr_run;
    assign o_busy  = (r_st != S_IDLE) || r_clr_run;

    logic          h_we, n_we;
    logic [CW-1:0] h_wa, h_ra;
    logic [EW-1:0] h_wd, n_wd;
    logic [PW-1:0] n_wa, n_ra;

    always_comb begin
        h_we = 1'b0; h_wa = r_nc; h_wd = '0; h_ra = r_oc;
        n_we = 1'b0; n_wa = r_in.particle[PW-1:0]; n_wd = '0;
        n_ra = r_cur[PW-1:0];
        unique case (r_st)
            S_DEC:   h_ra = (r_in.func == clb_pkg::FUNC_MOVE) ? b_cell_o : b_cell_n;
            // keep the new cell's head on r_hq for the push
            S_RDH:   h_ra = r_nc;
            // fetch the successor of the node on hand so that the walk state finds it on r_nq
            S_CHK:   n_ra = hd[PW-1:0];
            S_WALK:  n_ra = r_nq[PW-1:0];
            S_RDQ:   n_ra = r_in.particle[PW-1:0];
            S_UNL: begin
                if (r_hprev) begin
                    n_we = 1'b1; n_wa = r_prev; n_wd = r_nq;
                end else begin
                    h_we = 1'b1; h_wa = r_oc; h_wd = r_nq;
                end
            end
            S_PUSHW: begin
                n_we = 1'b1; n_wd = hd;
                h_we = 1'b1; h_wa = r_nc; h_wd = {1'b1, r_in.particle[PW-1:0]};
            end
            S_PUSHR: h_ra = r_nc;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_run) begin
            m_head[r_clr] <= '0;
        end else if (h_we) begin
            m_head[h_wa] <= {r_epoch, h_wd};
        end
        r_hq <= m_head[h_ra];
        if (n_we) begin
            m_next[n_wa] <= n_wd;
        end
        r_nq <= m_next[n_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            o_valid   <= 1'b0;
            r_epoch   <= TW'(1);
            r_clr     <= '0;
            r_clr_run <= 1'b1;
        end else begin
            if (o_valid && !i_stall && r_st != S_OUT) o_valid <= 1'b0;
            if (r_clr_run) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == CW'(MAX_CELLS - 1)) r_clr_run <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: if (i_valid && !o_stall) begin
                    r_in <= i_data;
                    r_st <= S_BIN1;
                end
                S_BIN1: r_st <= S_BIN2;
                S_BIN2: r_st <= S_DEC;
                S_DEC: begin
                    r_oc <= b_cell_o; r_nc <= b_cell_n;
                    r_status <= clb_pkg::ST_OK; r_oidx <= '0; r_ep <= '0;
                    unique case (r_in.func)
                        clb_pkg::FUNC_CLEAR: begin
                            // advance the epoch tag; when the tag wraps, sweep everything to zero
                            r_epoch <= (r_epoch == '1) ? TW'(1) : r_epoch + 1'b1;
                            if (r_epoch == '1) begin
                                r_clr_run <= 1'b1;
                                r_clr     <= '0;
                            end
                            r_st <= S_OUT;
                        end
                        clb_pkg::FUNC_INSERT: begin
                            if (!p_ok || !b_ok_n) begin
                                r_status <= clb_pkg::ST_RANGE; r_st <= S_OUT;
                            end else r_st <= S_RDH;
                        end
                        clb_pkg::FUNC_MOVE: begin
                            if (!p_ok || !b_ok_o || !b_ok_n) begin
                                r_status <= clb_pkg::ST_RANGE; r_st <= S_OUT;
                            end else r_st <= S_CHK;
                        end
                        clb_pkg::FUNC_HEAD: begin
                            if (!b_ok_n) begin
                                r_status <= clb_pkg::ST_RANGE; r_st <= S_OUT;
                            end else r_st <= S_RDH;
                        end
                        clb_pkg::FUNC_NEXT: begin
                            if (!p_ok) begin
                                r_status <= clb_pkg::ST_RANGE; r_st <= S_OUT;
                            end else r_st <= S_RDQ;
                        end
                        default: r_st <= S_OUT;
                    endcase
                end
                S_RDH: begin
                    // head of new cell is on hand; insert and move push, head query reports
                    r_oidx <= r_nc;
                    if (r_in.func == clb_pkg::FUNC_HEAD) begin
                        r_ep <= hd; r_st <= S_OUT;
                    end else begin
                        r_st <= S_PUSHW;
                    end
                end
                S_CHK: begin
                    if (!hd[EW-1]) begin
                        r_status <= clb_pkg::ST_EMPTY; r_st <= S_OUT;
                    end else begin
                        r_cur <= hd; r_hprev <= 1'b0; r_steps <= '0;
                        if (hd[PW-1:0] == r_in.particle[PW-1:0]) r_st <= S_RDN;
                        else r_st <= S_WALK;
                    end
                end
                S_WALK: begin
                    // successor of r_cur now on r_nq
                    r_prev <= r_cur[PW-1:0]; r_hprev <= 1'b1;
                    r_cur <= r_nq; r_steps <= r_steps + 1'b1;
                    if (!r_nq[EW-1] || r_steps == SW'(MAX_PARTICLES - 1)) begin
                        r_status <= clb_pkg::ST_MISSING; r_st <= S_PUSHR;
                    end else if (r_nq[PW-1:0] == r_in.particle[PW-1:0]) r_st <= S_RDN;
                end
                S_RDN: r_st <= S_UNL;
                S_UNL: r_st <= S_PUSHR;
                S_PUSHR: r_st <= S_RDH;
                S_PUSHW: begin
                    r_oidx <= r_nc; r_ep <= '0; r_st <= S_OUT;
                end
                S_RDQ: r_st <= S_NQ;
                S_NQ: begin
                    r_ep <= r_nq; r_st <= S_OUT;
                end
                S_OUT: if (!o_valid || !i_stall) begin
                    o_valid <= 1'b1;
                    o_data.status <= r_status;
                    o_data.cell_id <= 12'(r_oidx);
                    o_data.entry_particle <= r_ep[EW-1] ? 12'(r_ep[PW-1:0]) : 12'd0;
                    o_data.entry_valid <= r_ep[EW-1];
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/cell_list_binning_table_unit.sv
`default_nettype none
// channel   dir  handshake           payload
// in        in   i_valid / o_stall   i_data  (clb_pkg::t_in_word)
// out       out  o_valid / i_stall   o_data  (clb_pkg::t_out_word)
// cfg       in   i_cfg_we            i_cfg_idx, i_cfg_data
// A word is taken only while the sequencer is idle; a move walks the list of the
// old cell from its head node to the particle (to the list's end when the
// particle is missing), and the walk fetches one node a cycle.
// After reset a head-memory sweep runs before the first word is taken; every
// 15th clear repeats that sweep. The output register holds a word under stall;
// a new word may be taken meanwhile and waits to be handed off in its last
// cycle.
module cell_list_binning_table_unit #(
    parameter int MAX_PARTICLES = clb_pkg::MAX_PARTICLES_DEF,
    parameter int MAX_CELLS     = clb_pkg::MAX_CELLS_DEF,
    parameter int FRAC_BITS     = clb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [clb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [clb_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_valid,
    output      logic                          o_stall,
    input  wire clb_pkg::t_in_word             i_data,
    output      logic                          o_valid,
    input  wire logic                          i_stall,
    output      clb_pkg::t_out_word            o_data
);
    logic [4:0] r_cx, r_cy, r_cz;
    logic       busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= 5'd3; r_cy <= 5'd3; r_cz <= 5'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                clb_pkg::REG_CELLS_X: r_cx <= i_cfg_data;
                clb_pkg::REG_CELLS_Y: r_cy <= i_cfg_data;
                clb_pkg::REG_CELLS_Z: r_cz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    clb_ctrl #(.MAX_PARTICLES(MAX_PARTICLES), .MAX_CELLS(MAX_CELLS),
               .FRAC_BITS(FRAC_BITS)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_cx(clb_pkg::sat_cells(r_cx)), .i_cy(clb_pkg::sat_cells(r_cy)),
        .i_cz(clb_pkg::sat_cells(r_cz)),
        .i_valid, .o_stall, .i_data, .o_valid, .i_stall, .o_data, .o_busy(busy));

`ifndef NO_ASSERTIONS
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> o_stall) else $error("accepting while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data))) else $error("output dropped");
    a_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.entry_valid) |-> (o_data.entry_particle == 12'd0))
        else $error("entry particle without valid");
`endif
endmodule
`default_nettype wire

FILE: dv/tb_cell_list_binning_table_unit.sv
`default_nettype none
module tb_cell_list_binning_table_unit;
    localparam int NPART      = 4096;
    localparam int NCELL      = 4096;
    localparam int STALL_LIMIT = 60000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam logic [16:0] C_MAX = 17'd65535;
    localparam logic [16:0] C_OUT = 17'd65536;
    localparam logic [16:0] C_TOP = 17'd131071;

    typedef struct packed {
        logic        valid;
        logic [11:0] idx;
    } t_link;

    typedef struct {
        clb_pkg::t_in_word  w;
        bit                 typed;
        clb_pkg::t_out_word want;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [clb_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [clb_pkg::CFG_W-1:0]     i_cfg_data;
    logic       i_valid;
    logic       o_stall;
    clb_pkg::t_in_word   i_data;
    logic       o_valid;
    logic       i_stall;
    clb_pkg::t_out_word  o_data;

    cell_list_binning_table_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    // shadow of the binning table
    t_link     head_tbl [NCELL];
    t_link     next_tbl [NPART];
    bit        next_set [NPART];
    int        ncx, ncy, ncz;

    // stimulus bookkeeping: where each particle was last placed
    bit          placed [NPART];
    logic [16:0] at_x [NPART], at_y [NPART], at_z [NPART];
    int          placed_ids [$];

    clb_pkg::t_out_word pending_words [$];
    int        errors;
    bit        calm;
    int        quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int clamp_cells(input logic [4:0] r);
        if (r < 3) return 3;
        if (r > 16) return 16;
        return r;
    endfunction

    function automatic bit locate(input logic [16:0] x, input logic [16:0] y,
                                  input logic [16:0] z, output int bin);
        int bx, by, bz;
        bx = (int'(x) * ncx) >> 16;
        by = (int'(y) * ncy) >> 16;
        bz = (int'(z) * ncz) >> 16;
        bin = 0;
        if (bx >= ncx || by >= ncy || bz >= ncz) return 1'b0;
        bin = ncx * ncy * bz + ncx * by + bx;
        return bin < NCELL;
    endfunction

    function automatic void push_front(input int bin, input int p);
        next_tbl[p] = head_tbl[bin];
        next_set[p] = 1'b1;
        head_tbl[bin] = '{valid: 1'b1, idx: p[11:0]};
    endfunction

    function automatic bit unlink(input int bin, input int p);
        t_link cur;
        bit    have_prev;
        int    prev;
        cur = head_tbl[bin];
        have_prev = 1'b0;
        prev = 0;
        for (int n = 0; n < NPART && cur.valid; n++) begin
            if (cur.idx == p) begin
                if (have_prev) next_tbl[prev] = next_tbl[cur.idx];
                else head_tbl[bin] = next_tbl[cur.idx];
                return 1'b1;
            end
            prev = cur.idx;
            have_prev = 1'b1;
            cur = next_tbl[cur.idx];
        end
        return 1'b0;
    endfunction

    function automatic clb_pkg::t_out_word bin_and_link(input clb_pkg::t_in_word w);
        clb_pkg::t_out_word r;
        int oc, nc, p;
        r = '0;
        p = w.particle;
        case (w.func)
            clb_pkg::FUNC_CLEAR: begin
                foreach (head_tbl[i]) head_tbl[i] = '0;
            end
            clb_pkg::FUNC_INSERT: begin
                if (!locate(w.new_x, w.new_y, w.new_z, nc)) begin
                    r.status = clb_pkg::ST_RANGE;
                end else begin
                    push_front(nc, p);
                    r.cell_id = nc[11:0];
                end
            end
            clb_pkg::FUNC_MOVE: begin
                if (!locate(w.old_x, w.old_y, w.old_z, oc) ||
                    !locate(w.new_x, w.new_y, w.new_z, nc)) begin
                    r.status = clb_pkg::ST_RANGE;
                end else if (!head_tbl[oc].valid) begin
                    r.status = clb_pkg::ST_EMPTY;
                end else begin
                    if (!unlink(oc, p)) r.status = clb_pkg::ST_MISSING;
                    push_front(nc, p);
                    r.cell_id = nc[11:0];
                end
            end
            clb_pkg::FUNC_HEAD: begin
                if (!locate(w.new_x, w.new_y, w.new_z, nc)) begin
                    r.status = clb_pkg::ST_RANGE;
                end else begin
                    r.cell_id = nc[11:0];
                    r.entry_valid = head_tbl[nc].valid;
                    if (head_tbl[nc].valid) r.entry_particle = head_tbl[nc].idx;
                end
            end
            clb_pkg::FUNC_NEXT: begin
                r.entry_valid = next_tbl[p].valid;
                if (next_tbl[p].valid) r.entry_particle = next_tbl[p].idx;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // output side: random stall, check each handed-off word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_words.size() == 0) begin
                    report("unexpected word", int'(o_data), 0);
                end else begin
                    if (o_data.status != pending_words[0].status)
                        report("status", o_data.status, pending_words[0].status);
                    if (o_data.cell_id != pending_words[0].cell_id)
                        report("cell_id", o_data.cell_id, pending_words[0].cell_id);
                    if (o_data.entry_particle != pending_words[0].entry_particle)
                        report("entry_particle", o_data.entry_particle,
                               pending_words[0].entry_particle);
                    if (o_data.entry_valid != pending_words[0].entry_valid)
                        report("entry_valid", o_data.entry_valid, pending_words[0].entry_valid);
                    void'(pending_words.pop_front());
                end
            end
            i_stall <= !calm && ($urandom_range(0, 99) < 6);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send(input clb_pkg::t_in_word w, input bit typed,
                        input clb_pkg::t_out_word want);
        clb_pkg::t_out_word got;
        if (!calm && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        got = bin_and_link(w);
        pending_words.push_back(typed ? want : got);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [clb_pkg::CFG_IDX_W-1:0] idx, input logic [4:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            clb_pkg::REG_CELLS_X: ncx = clamp_cells(val);
            clb_pkg::REG_CELLS_Y: ncy = clamp_cells(val);
            default:              ncz = clamp_cells(val);
        endcase
    endtask

    function automatic clb_pkg::t_in_word mk(input logic [2:0] f, input int p,
                                    input logic [16:0] ox, input logic [16:0] oy,
                                    input logic [16:0] oz, input logic [16:0] nx,
                                    input logic [16:0] ny, input logic [16:0] nz);
        clb_pkg::t_in_word w;
        w.func = f; w.particle = p[11:0];
        w.old_x = ox; w.old_y = oy; w.old_z = oz;
        w.new_x = nx; w.new_y = ny; w.new_z = nz;
        return w;
    endfunction

    function automatic t_row row(input clb_pkg::t_in_word w, input bit typed,
                                 input logic [1:0] st, input int ci, input int ep,
                                 input bit ev);
        t_row r;
        r.w = w;
        r.typed = typed;
        r.want = '{status: st, cell_id: ci[11:0], entry_particle: ep[11:0],
                   entry_valid: ev};
        return r;
    endfunction

    function automatic logic [16:0] rnd_in();
        return 17'($urandom_range(0, 65535));
    endfunction

    function automatic void forget_places();
        foreach (placed[i]) placed[i] = 1'b0;
        placed_ids.delete();
    endfunction

    function automatic void note_place(input int p, input logic [16:0] x,
                                       input logic [16:0] y, input logic [16:0] z);
        if (!placed[p]) placed_ids.push_back(p);
        placed[p] = 1'b1;
        at_x[p] = x; at_y[p] = y; at_z[p] = z;
    endfunction

    task automatic random_item();
        clb_pkg::t_in_word w;
        int r, p, k, tries;
        r = $urandom_range(0, 99);
        w = mk(clb_pkg::FUNC_HEAD, $urandom_range(0, NPART - 1), rnd_in(), rnd_in(),
               rnd_in(), rnd_in(), rnd_in(), rnd_in());
        if (r == 0) begin
            w.func = clb_pkg::FUNC_CLEAR;
            forget_places();
        end else if (r <= 30 || (r <= 60 && placed_ids.size() == 0)) begin
            w.func = clb_pkg::FUNC_INSERT;
            tries = 0;
            while (placed[w.particle] && tries < 8) begin
                w.particle = $urandom_range(0, NPART - 1);
                tries++;
            end
            note_place(w.particle, w.new_x, w.new_y, w.new_z);
        end else if (r <= 60) begin
            w.func = clb_pkg::FUNC_MOVE;
            k = $urandom_range(0, placed_ids.size() - 1);
            p = placed_ids[k];
            w.particle = p;
            w.old_x = at_x[p]; w.old_y = at_y[p]; w.old_z = at_z[p];
            note_place(p, w.new_x, w.new_y, w.new_z);
        end else if (r <= 72) begin
            if (placed_ids.size() != 0 && $urandom_range(0, 1)) begin
                p = placed_ids[$urandom_range(0, placed_ids.size() - 1)];
                w.new_x = at_x[p]; w.new_y = at_y[p]; w.new_z = at_z[p];
            end
        end else begin
            if (r <= 82) w.func = clb_pkg::FUNC_NEXT;
            else w.func = 3'($urandom_range(1, 7));
            if (r > 82) begin
                // broken words: any coordinate, either bit 16 value
                w.old_x = 17'($urandom); w.old_y = 17'($urandom); w.old_z = 17'($urandom);
                w.new_x = 17'($urandom); w.new_y = 17'($urandom); w.new_z = 17'($urandom);
                if ($urandom_range(0, 1)) begin
                    w.old_x[16] = 1'b0; w.old_y[16] = 1'b0; w.old_z[16] = 1'b0;
                    w.new_x[16] = 1'b0; w.new_y[16] = 1'b0; w.new_z[16] = 1'b0;
                end
            end
            if (w.func == clb_pkg::FUNC_NEXT) begin
                // never read a successor entry that was not written
                tries = 0;
                while (!next_set[w.particle] && tries < 64) begin
                    w.particle = $urandom_range(0, NPART - 1);
                    tries++;
                end
                if (!next_set[w.particle]) begin
                    if (placed_ids.size() != 0)
                        w.particle = placed_ids[$urandom_range(0, placed_ids.size() - 1)];
                    else
                        w.func = clb_pkg::FUNC_HEAD;
                end
            end
        end
        send(w, 1'b0, '0);
    endtask

    initial begin
        t_row rows [$];
        logic [4:0] cfg_set [6][3];
        errors = 0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        ncx = 3; ncy = 3; ncz = 3;
        foreach (head_tbl[i]) head_tbl[i] = '0;
        foreach (next_tbl[i]) begin
            next_tbl[i] = '0;
            next_set[i] = 1'b0;
        end
        forget_places();
        cfg_set = '{'{5'd16, 5'd16, 5'd16}, '{5'd0, 5'd31, 5'd5}, '{5'd7, 5'd4, 5'd12},
                    '{5'd3, 5'd16, 5'd3}, '{5'd31, 5'd2, 5'd9}, '{5'd3, 5'd3, 5'd3}};

        // directed: 3x3x3 cells after reset; top corner is cell 26
        rows.push_back(row(mk(clb_pkg::FUNC_HEAD, 0, 0, 0, 0, 0, 0, 0), 1,
                           clb_pkg::ST_OK, 0, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_HEAD, 0, 0, 0, 0, C_TOP, C_TOP, C_TOP), 1,
                           clb_pkg::ST_RANGE, 0, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_INSERT, 5, 0, 0, 0, 0, 0, 0), 1,
                           clb_pkg::ST_OK, 0, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_INSERT, 4095, 0, 0, 0, C_MAX, C_MAX, C_MAX), 1,
                           clb_pkg::ST_OK, 26, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_HEAD, 0, 0, 0, 0, C_MAX, C_MAX, C_MAX), 1,
                           clb_pkg::ST_OK, 26, 4095, 1));
        rows.push_back(row(mk(clb_pkg::FUNC_NEXT, 4095, 0, 0, 0, 0, 0, 0), 1,
                           clb_pkg::ST_OK, 0, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_INSERT, 0, 0, 0, 0, C_MAX, C_MAX, C_MAX), 0,
                           clb_pkg::ST_OK, 0, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_MOVE, 5, 0, 0, 0, C_MAX, C_MAX, C_MAX), 0,
                           clb_pkg::ST_OK, 0, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_MOVE, 7, 0, 0, 0, C_MAX, 0, 0), 1,
                           clb_pkg::ST_EMPTY, 0, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_MOVE, 9, C_MAX, C_MAX, C_MAX, 0, C_MAX, 0), 0,
                           clb_pkg::ST_OK, 0, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_MOVE, 4095, C_MAX, C_MAX, C_MAX, 0, 0, 0), 0,
                           clb_pkg::ST_OK, 0, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_MOVE, 0, C_OUT, C_MAX, C_MAX, 0, 0, 0), 1,
                           clb_pkg::ST_RANGE, 0, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_MOVE, 0, C_MAX, C_MAX, C_MAX, 0, 0, C_OUT), 1,
                           clb_pkg::ST_RANGE, 0, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_INSERT, 1, 0, 0, 0, 0, C_TOP, 0), 1,
                           clb_pkg::ST_RANGE, 0, 0, 0));
        rows.push_back(row(mk(3'd5, 4095, C_TOP, C_TOP, C_TOP, C_TOP, C_TOP, C_TOP), 1,
                           clb_pkg::ST_OK, 0, 0, 0));
        rows.push_back(row(mk(3'd6, 1, 0, 0, 0, 0, 0, 0), 1, clb_pkg::ST_OK, 0, 0, 0));
        rows.push_back(row(mk(3'd7, 0, 1, 1, 1, 1, 1, 1), 1, clb_pkg::ST_OK, 0, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_NEXT, 5, 0, 0, 0, 0, 0, 0), 0,
                           clb_pkg::ST_OK, 0, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_HEAD, 0, 0, 0, 0, C_MAX, C_MAX, C_MAX), 0,
                           clb_pkg::ST_OK, 0, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1,
                           clb_pkg::ST_OK, 0, 0, 0));
        rows.push_back(row(mk(clb_pkg::FUNC_HEAD, 0, 0, 0, 0, C_MAX, C_MAX, C_MAX), 1,
                           clb_pkg::ST_OK, 26, 0, 0));
        // successors survive a clear
        rows.push_back(row(mk(clb_pkg::FUNC_NEXT, 5, 0, 0, 0, 0, 0, 0), 0,
                           clb_pkg::ST_OK, 0, 0, 0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) send(rows[i].w, rows[i].typed, rows[i].want);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_reg(clb_pkg::REG_CELLS_X, cfg_set[ph][0]);
            write_reg(clb_pkg::REG_CELLS_Y, cfg_set[ph][1]);
            write_reg(clb_pkg::REG_CELLS_Z, cfg_set[ph][2]);
            calm = (ph == 2);
            forget_places();
            send(mk(clb_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
            repeat (ITEMS_PER_PHASE) random_item();
        end
        calm = 1'b0;
        drain();

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
